@@ rtl/lsig_pkg.sv @@
// ----------------------------------------------------------------------------
// lsig_pkg: shared types and constants of the skirt index generator
// Item, quad descriptor and region codes used by the front queue, the walk
// stage and the index stage.
// ----------------------------------------------------------------------------
package lsig_pkg;

    // field widths fixed by the interface
    localparam int IW    = 17;
    localparam int CFG_W = 4;
    localparam int POS_W = 9;

    localparam logic [CFG_W-1:0] CHUNK_LOG2_RESET = 4'd6;

    // front queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic {
        OP_NEXT  = 1'b0,
        OP_START = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        REG_SURFACE = 3'd0,
        REG_LEFT    = 3'd1,
        REG_RIGHT   = 3'd2,
        REG_TOP     = 3'd3,
        REG_BOTTOM  = 3'd4
    } t_region;

    typedef struct packed {
        t_op              op;
        logic [CFG_W-1:0] lod;
    } t_item;

    // head of the front queue as seen by the walk stage
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    // one quad, handed from the walk stage to the index stage
    typedef struct packed {
        logic             valid_res;
        t_region          region;
        logic             last;
        logic [CFG_W-1:0] size_log2;
        logic [IW-1:0]    skip;
        logic [IW-1:0]    row;
        logic [IW-1:0]    col;
    } t_quad;

    // skirt side order: left, right, top, bottom
    function automatic t_region next_side(input t_region cur);
        t_region nxt;
        case (cur)
            REG_LEFT:  nxt = REG_RIGHT;
            REG_RIGHT: nxt = REG_TOP;
            REG_TOP:   nxt = REG_BOTTOM;
            default:   nxt = REG_BOTTOM;
        endcase
        return nxt;
    endfunction

endpackage

@@ rtl/lsig_front.sv @@
// ----------------------------------------------------------------------------
// lsig_front: input acceptance and item queue
// Takes input transactions, tags them as start or next requests and holds
// them in a short queue until the walk stage pops them.
// ----------------------------------------------------------------------------
module lsig_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_start_req,
    input  logic [lsig_pkg::CFG_W-1:0]    i_lod_level,
    input  logic                          i_pop,
    output lsig_pkg::t_head               o_head
);

    lsig_pkg::t_item                       r_mem [lsig_pkg::FIFO_DEPTH];
    logic [lsig_pkg::FIFO_PTR_W-1:0]       r_wr_ptr;
    logic [lsig_pkg::FIFO_PTR_W-1:0]       r_rd_ptr;
    logic [lsig_pkg::FIFO_CNT_W-1:0]       r_count;
    logic [lsig_pkg::FIFO_CNT_W-1:0]       n_count;
    logic                                  push;
    logic                                  pop;
    lsig_pkg::t_item                       in_item;

    // classify the incoming transaction
    always_comb begin
        in_item.op  = i_start_req ? lsig_pkg::OP_START : lsig_pkg::OP_NEXT;
        in_item.lod = i_lod_level;
    end

    // full flag comes from the registered count only
    assign o_stall = (r_count == lsig_pkg::FIFO_CNT_W'(lsig_pkg::FIFO_DEPTH));
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    // occupancy update
    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + lsig_pkg::FIFO_CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - lsig_pkg::FIFO_CNT_W'(1);
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + lsig_pkg::FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + lsig_pkg::FIFO_PTR_W'(1);
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_item;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lsig_pkg::FIFO_CNT_W'(lsig_pkg::FIFO_DEPTH))
        else $error("front queue count past depth");
`endif

endmodule

@@ rtl/lsig_walk.sv @@
// ----------------------------------------------------------------------------
// lsig_walk: run state and quad sequencing
// Owns the chunk size register and the run counters, steps one queued item
// per cycle while the index stage is ready and hands a quad descriptor to the index stage.
// ----------------------------------------------------------------------------
module lsig_walk #(
    parameter int MAX_CHUNK_LOG2 = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [lsig_pkg::CFG_W-1:0]    i_cfg_data,
    input  lsig_pkg::t_head               i_head,
    output logic                          o_pop,
    input  logic                          i_emit_ready,
    output logic                          o_desc_valid,
    output lsig_pkg::t_quad               o_desc
);

    localparam int PW = ((MAX_CHUNK_LOG2 > 8) ? MAX_CHUNK_LOG2 : 8) + 2;
    localparam logic [lsig_pkg::CFG_W-1:0] MAX_L = lsig_pkg::CFG_W'(MAX_CHUNK_LOG2);

    logic [lsig_pkg::CFG_W-1:0]   r_chunk_log2;
    logic                         r_active;
    logic [lsig_pkg::CFG_W-1:0]   r_lod;
    logic [lsig_pkg::POS_W-1:0]   r_row;
    logic [lsig_pkg::POS_W-1:0]   r_col;
    lsig_pkg::t_region            r_region;
    logic                         r_desc_valid;
    lsig_pkg::t_quad              r_desc;

    logic                         n_active;
    logic [lsig_pkg::CFG_W-1:0]   n_lod;
    logic [lsig_pkg::POS_W-1:0]   n_row;
    logic [lsig_pkg::POS_W-1:0]   n_col;
    lsig_pkg::t_region            n_region;

    logic [lsig_pkg::CFG_W-1:0]   eff_l;
    logic [lsig_pkg::CFG_W-1:0]   eff_lod;
    logic [PW-1:0]                size_n;
    logic [PW-1:0]                skip;
    logic [PW-1:0]                nr_row;
    logic [PW-1:0]                nr_col;
    lsig_pkg::t_region            nr_region;
    logic                         exhausted;
    logic                         run_ok;
    logic [PW-1:0]                c_adv;
    logic [PW-1:0]                r_adv;
    logic                         take;
    logic                         is_next;
    lsig_pkg::t_quad              d_quad;

    // effective size and skip rate
    always_comb begin
        eff_l   = (r_chunk_log2 > MAX_L) ? MAX_L : r_chunk_log2;
        eff_lod = (r_lod > eff_l) ? eff_l : r_lod;
        size_n  = PW'(1) << eff_l;
        skip    = PW'(1) << eff_lod;
    end

    // pull positions back inside the chunk after a size change
    always_comb begin
        nr_row    = PW'(r_row);
        nr_col    = PW'(r_col);
        nr_region = r_region;
        exhausted = 1'b0;
        if (r_region == lsig_pkg::REG_SURFACE) begin
            if (nr_col >= size_n) begin
                nr_col = '0;
                nr_row = PW'(r_row) + skip;
            end
            if (nr_row >= size_n) begin
                nr_region = lsig_pkg::REG_LEFT;
                nr_col    = '0;
            end
        end
        if (nr_region != lsig_pkg::REG_SURFACE && nr_col >= size_n) begin
            nr_col = '0;
            if (nr_region == lsig_pkg::REG_BOTTOM) begin
                exhausted = 1'b1;
            end else begin
                nr_region = lsig_pkg::next_side(nr_region);
            end
        end
        run_ok = r_active && !exhausted;
        c_adv  = nr_col + skip;
        r_adv  = nr_row + skip;
    end

    // handshake toward the queue and the index stage
    assign take    = i_head.valid && (!r_desc_valid || i_emit_ready);
    assign o_pop   = take;
    assign is_next = take && (i_head.item.op == lsig_pkg::OP_NEXT);

    // next run state
    always_comb begin
        n_active = r_active;
        n_lod    = r_lod;
        n_row    = r_row;
        n_col    = r_col;
        n_region = r_region;
        if (i_head.item.op == lsig_pkg::OP_START) begin
            n_active = 1'b1;
            n_lod    = i_head.item.lod;
            n_row    = '0;
            n_col    = '0;
            n_region = lsig_pkg::REG_SURFACE;
        end else if (!run_ok) begin
            n_active = 1'b0;
        end else begin
            n_region = nr_region;
            n_row    = nr_row[lsig_pkg::POS_W-1:0];
            n_col    = c_adv[lsig_pkg::POS_W-1:0];
            if (c_adv >= size_n) begin
                n_col = '0;
                if (nr_region == lsig_pkg::REG_SURFACE) begin
                    if (r_adv >= size_n) begin
                        n_row    = '0;
                        n_region = lsig_pkg::REG_LEFT;
                    end else begin
                        n_row = r_adv[lsig_pkg::POS_W-1:0];
                    end
                end else if (nr_region == lsig_pkg::REG_BOTTOM) begin
                    n_active = 1'b0;
                    n_region = lsig_pkg::REG_SURFACE;
                end else begin
                    n_region = lsig_pkg::next_side(nr_region);
                end
            end
        end
    end

    // quad descriptor for the index stage
    always_comb begin
        d_quad = '0;
        if (run_ok) begin
            d_quad.valid_res = 1'b1;
            d_quad.region    = nr_region;
            d_quad.last      = (nr_region == lsig_pkg::REG_BOTTOM) && (c_adv >= size_n);
            d_quad.size_log2 = eff_l;
            d_quad.skip      = lsig_pkg::IW'(skip);
            d_quad.row       = lsig_pkg::IW'(nr_row);
            d_quad.col       = lsig_pkg::IW'(nr_col);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_log2 <= lsig_pkg::CHUNK_LOG2_RESET;
            r_active     <= 1'b0;
            r_lod        <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_region     <= lsig_pkg::REG_SURFACE;
            r_desc_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_chunk_log2 <= i_cfg_data;
            end
            if (take) begin
                r_active <= n_active;
                r_lod    <= n_lod;
                r_row    <= n_row;
                r_col    <= n_col;
                r_region <= n_region;
            end
            if (!r_desc_valid || i_emit_ready) begin
                r_desc_valid <= is_next;
            end
        end
    end

    // descriptor payload
    always_ff @(posedge i_clk) begin
        if (is_next) begin
            r_desc <= d_quad;
        end
    end

    assign o_desc_valid = r_desc_valid;
    assign o_desc       = r_desc;

`ifndef SYNTH
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_next && d_quad.last) |=> !r_active)
        else $error("run still active after final bottom skirt quad");
`endif

endmodule

@@ rtl/lsig_emit.sv @@
// ----------------------------------------------------------------------------
// lsig_emit: vertex index computation and result register
// Turns a quad descriptor into its six vertex indices and holds the result
// until the output transaction completes.
// ----------------------------------------------------------------------------
module lsig_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_desc_valid,
    input  lsig_pkg::t_quad               i_desc,
    output logic                          o_ready,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_valid_res,
    output logic [2:0]                    o_region,
    output logic [lsig_pkg::IW-1:0]       o_first_index,
    output logic [lsig_pkg::IW-1:0]       o_second_index,
    output logic [lsig_pkg::IW-1:0]       o_third_index,
    output logic [lsig_pkg::IW-1:0]       o_fourth_index,
    output logic [lsig_pkg::IW-1:0]       o_fifth_index,
    output logic [lsig_pkg::IW-1:0]       o_sixth_index,
    output logic                          o_last_quad
);

    logic                         r_valid;
    logic                         r_valid_res;
    lsig_pkg::t_region            r_region;
    logic [lsig_pkg::IW-1:0]      r_idx [6];
    logic                         r_last;

    logic [lsig_pkg::IW-1:0]      size_n;
    logic [lsig_pkg::IW-1:0]      skip_stride;
    logic [lsig_pkg::IW-1:0]      corner_a;
    logic [lsig_pkg::IW-1:0]      corner_b;
    logic [lsig_pkg::IW-1:0]      corner_d;
    logic [lsig_pkg::IW-1:0]      corner_e;
    logic [lsig_pkg::IW-1:0]      side_k;
    logic [lsig_pkg::IW-1:0]      skirt_base;
    logic [lsig_pkg::IW-1:0]      sv0;
    logic [lsig_pkg::IW-1:0]      sv1;
    logic [lsig_pkg::IW-1:0]      ev0;
    logic [lsig_pkg::IW-1:0]      ev1;
    logic [lsig_pkg::IW-1:0]      edge_step;
    logic [lsig_pkg::IW-1:0]      col_stride;
    logic [lsig_pkg::IW-1:0]      idx [6];

    assign o_ready = !r_valid || !i_stall;

    // indices, all arithmetic modulo the index width; x*stride = (x << L) + x
    always_comb begin
        size_n      = lsig_pkg::IW'(1) << i_desc.size_log2;
        skip_stride = (i_desc.skip << i_desc.size_log2) + i_desc.skip;

        // surface corners
        corner_a = (i_desc.row << i_desc.size_log2) + i_desc.row + i_desc.col;
        corner_b = corner_a + i_desc.skip;
        corner_d = corner_a + skip_stride;
        corner_e = corner_d + i_desc.skip;

        // skirt vertices of this side
        side_k     = lsig_pkg::IW'(i_desc.region) - lsig_pkg::IW'(lsig_pkg::REG_LEFT);
        skirt_base = (size_n << i_desc.size_log2) + (size_n << 1) + lsig_pkg::IW'(1);
        sv0        = skirt_base + (side_k << i_desc.size_log2) + side_k + i_desc.col;
        sv1        = sv0 + i_desc.skip;

        // edge vertices along the chunk border
        col_stride = (i_desc.col << i_desc.size_log2) + i_desc.col;
        edge_step  = i_desc.skip;
        case (i_desc.region)
            lsig_pkg::REG_LEFT: begin
                ev0       = col_stride;
                edge_step = skip_stride;
            end
            lsig_pkg::REG_RIGHT: begin
                ev0       = col_stride + size_n;
                edge_step = skip_stride;
            end
            lsig_pkg::REG_TOP: begin
                ev0 = i_desc.col;
            end
            default: begin
                ev0 = i_desc.col + (size_n << i_desc.size_log2) + size_n;
            end
        endcase
        ev1 = ev0 + edge_step;

        // winding by region
        case (i_desc.region)
            lsig_pkg::REG_SURFACE: begin
                idx[0] = corner_d; idx[1] = corner_b; idx[2] = corner_a;
                idx[3] = corner_e; idx[4] = corner_b; idx[5] = corner_d;
            end
            lsig_pkg::REG_LEFT, lsig_pkg::REG_BOTTOM: begin
                idx[0] = ev0; idx[1] = sv1; idx[2] = ev1;
                idx[3] = ev0; idx[4] = sv0; idx[5] = sv1;
            end
            default: begin
                idx[0] = ev0; idx[1] = ev1; idx[2] = sv0;
                idx[3] = ev1; idx[4] = sv1; idx[5] = sv0;
            end
        endcase

        // no active run gives an all-zero result
        if (!i_desc.valid_res) begin
            for (int j = 0; j < 6; j++) begin
                idx[j] = '0;
            end
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_desc_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_desc_valid) begin
            r_valid_res <= i_desc.valid_res;
            r_region    <= i_desc.region;
            r_last      <= i_desc.last;
            for (int j = 0; j < 6; j++) begin
                r_idx[j] <= idx[j];
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_valid_res    = r_valid_res;
    assign o_region       = r_region;
    assign o_first_index  = r_idx[0];
    assign o_second_index = r_idx[1];
    assign o_third_index  = r_idx[2];
    assign o_fourth_index = r_idx[3];
    assign o_fifth_index  = r_idx[4];
    assign o_sixth_index  = r_idx[5];
    assign o_last_quad    = r_last;

`ifndef SYNTH
    a_last_is_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_valid_res && r_region == lsig_pkg::REG_BOTTOM))
        else $error("final quad flagged outside the bottom skirt");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_valid_res) |-> (r_region == lsig_pkg::REG_SURFACE && !r_last
            && r_idx[0] == '0 && r_idx[1] == '0 && r_idx[2] == '0
            && r_idx[3] == '0 && r_idx[4] == '0 && r_idx[5] == '0))
        else $error("result without an active run is not all zero");
    a_hand_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_desc_valid && o_ready) |=> r_valid)
        else $error("accepted descriptor did not reach the result register");
`endif

endmodule

@@ rtl/grid_lod_skirt_index_generator.sv @@
// A next request passes the queue, the walk stage's descriptor register and the result register.
// Throughput: 1 item per cycle while i_stall is low, set by the counter update of the walk stage.
// A start request restarts the run and produces no result transaction.
// Reset (synchronous, active low) clears the queue, the run state and the result
// register, and returns chunk_size_log2 to 6.
// ----------------------------------------------------------------------------
// grid_lod_skirt_index_generator: terrain chunk triangle index generator
// Emits six vertex indices per quad, surface quads in row-major order then
// left, right, top and bottom skirt quads, at a selectable level of detail.
// ----------------------------------------------------------------------------
module grid_lod_skirt_index_generator #(
    parameter int MAX_CHUNK_LOG2 = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_start_req,
    input  logic [lsig_pkg::CFG_W-1:0]    i_lod_level,
    // configuration write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lsig_pkg::CFG_W-1:0]    i_cfg_chunk_size_log2,
    // result items
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_valid_res,
    output logic [2:0]                    o_region,
    output logic [lsig_pkg::IW-1:0]       o_first_index,
    output logic [lsig_pkg::IW-1:0]       o_second_index,
    output logic [lsig_pkg::IW-1:0]       o_third_index,
    output logic [lsig_pkg::IW-1:0]       o_fourth_index,
    output logic [lsig_pkg::IW-1:0]       o_fifth_index,
    output logic [lsig_pkg::IW-1:0]       o_sixth_index,
    output logic                          o_last_quad
);

    lsig_pkg::t_head   head;
    logic              pop;
    logic              emit_ready;
    logic              desc_valid;
    lsig_pkg::t_quad   desc;

    // register write always completes
    assign o_cfg_ready = 1'b1;

    // front: accept and queue
    lsig_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_start_req (i_start_req),
        .i_lod_level (i_lod_level),
        .i_pop       (pop),
        .o_head      (head)
    );

    // back: run sequencing
    lsig_walk #(
        .MAX_CHUNK_LOG2 (MAX_CHUNK_LOG2)
    ) u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_chunk_size_log2),
        .i_head       (head),
        .o_pop        (pop),
        .i_emit_ready (emit_ready),
        .o_desc_valid (desc_valid),
        .o_desc       (desc)
    );

    // back: index computation and result register
    lsig_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_desc_valid   (desc_valid),
        .i_desc         (desc),
        .o_ready        (emit_ready),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_valid_res    (o_valid_res),
        .o_region       (o_region),
        .o_first_index  (o_first_index),
        .o_second_index (o_second_index),
        .o_third_index  (o_third_index),
        .o_fourth_index (o_fourth_index),
        .o_fifth_index  (o_fifth_index),
        .o_sixth_index  (o_sixth_index),
        .o_last_quad    (o_last_quad)
    );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the terrain chunk skirt index generator
// Drives start and next-quad transactions with random gaps and stalls on both
// sides, predicts every quad's six indices, region and last flag with a local
// model of the surface and skirt walk, and compares each result in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_LOG2 = 8;

    // one result transaction
    typedef struct packed {
        logic                          valid_res;
        logic [2:0]                    region;
        logic [0:5][lsig_pkg::IW-1:0]  idx;
        logic                          last;
    } t_quad_res;

    // one input transaction plus its pacing and an optional fixed expectation
    typedef struct packed {
        lsig_pkg::t_op  op;
        logic [3:0]     lod;
        logic           pause;
        logic           typed;
        t_quad_res      res;
    } t_req;

    // directed table row, expected fields used only when typed is set
    typedef struct {
        lsig_pkg::t_op  op;
        logic [3:0]     lod;
        bit             typed;
        bit             vr;
        logic [2:0]     rg;
        int unsigned    i0, i1, i2, i3, i4, i5;
        bit             last;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_start_req = 1'b0;
    logic [lsig_pkg::CFG_W-1:0] i_lod_level = '0;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [lsig_pkg::CFG_W-1:0] i_cfg_chunk_size_log2;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_valid_res;
    logic [2:0] o_region;
    logic [lsig_pkg::IW-1:0] o_first_index, o_second_index, o_third_index;
    logic [lsig_pkg::IW-1:0] o_fourth_index, o_fifth_index, o_sixth_index;
    logic o_last_quad;

    // predictor state
    logic [3:0]  chunk_log2 = lsig_pkg::CHUNK_LOG2_RESET;
    bit          run_on = 1'b0;
    logic [3:0]  run_lod = '0;
    int unsigned row_pos = 0;
    int unsigned col_pos = 0;
    logic [2:0]  cur_region = lsig_pkg::REG_SURFACE;

    t_req       req_q[$];
    t_quad_res  quad_q[$];
    int         err_cnt = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    int         hold_req = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    // directed rows, default chunk of 64 tiles per side
    t_row dir_tab [22] = '{
        '{lsig_pkg::OP_NEXT,  4'd0,  1'b1, 1'b0, lsig_pkg::REG_SURFACE, 0, 0, 0, 0, 0, 0, 1'b0},
        '{lsig_pkg::OP_START, 4'd15, 1'b0, 1'b0, lsig_pkg::REG_SURFACE, 0, 0, 0, 0, 0, 0, 1'b0},
        '{lsig_pkg::OP_NEXT,  4'd0,  1'b1, 1'b1, lsig_pkg::REG_SURFACE,
          4160, 64, 0, 4224, 64, 4160, 1'b0},
        '{lsig_pkg::OP_NEXT,  4'd0,  1'b1, 1'b1, lsig_pkg::REG_LEFT,
          0, 4289, 4160, 0, 4225, 4289, 1'b0},
        '{lsig_pkg::OP_NEXT,  4'd0,  1'b1, 1'b1, lsig_pkg::REG_RIGHT,
          64, 4224, 4290, 4224, 4354, 4290, 1'b0},
        '{lsig_pkg::OP_NEXT,  4'd0,  1'b1, 1'b1, lsig_pkg::REG_TOP,
          0, 64, 4355, 64, 4419, 4355, 1'b0},
        '{lsig_pkg::OP_NEXT,  4'd0,  1'b1, 1'b1, lsig_pkg::REG_BOTTOM,
          4160, 4484, 4224, 4160, 4420, 4484, 1'b1},
        '{lsig_pkg::OP_NEXT,  4'd15, 1'b1, 1'b0, lsig_pkg::REG_SURFACE, 0, 0, 0, 0, 0, 0, 1'b0},
        '{lsig_pkg::OP_NEXT,  4'd0,  1'b1, 1'b0, lsig_pkg::REG_SURFACE, 0, 0, 0, 0, 0, 0, 1'b0},
        '{lsig_pkg::OP_START, 4'd0,  1'b0, 1'b0, lsig_pkg::REG_SURFACE, 0, 0, 0, 0, 0, 0, 1'b0},
        '{lsig_pkg::OP_NEXT,  4'd0,  1'b1, 1'b1, lsig_pkg::REG_SURFACE,
          65, 1, 0, 66, 1, 65, 1'b0},
        '{lsig_pkg::OP_NEXT,  4'd0,  1'b0, 1'b0, lsig_pkg::REG_SURFACE, 0, 0, 0, 0, 0, 0, 1'b0},
        '{lsig_pkg::OP_START, 4'd6,  1'b0, 1'b0, lsig_pkg::REG_SURFACE, 0, 0, 0, 0, 0, 0, 1'b0},
        '{lsig_pkg::OP_NEXT,  4'd0,  1'b0, 1'b0, lsig_pkg::REG_SURFACE, 0, 0, 0, 0, 0, 0, 1'b0},
        '{lsig_pkg::OP_START, 4'd7,  1'b0, 1'b0, lsig_pkg::REG_SURFACE, 0, 0, 0, 0, 0, 0, 1'b0},
        '{lsig_pkg::OP_NEXT,  4'd0,  1'b0, 1'b0, lsig_pkg::REG_SURFACE, 0, 0, 0, 0, 0, 0, 1'b0},
        '{lsig_pkg::OP_NEXT,  4'd0,  1'b0, 1'b0, lsig_pkg::REG_SURFACE, 0, 0, 0, 0, 0, 0, 1'b0},
        '{lsig_pkg::OP_START, 4'd8,  1'b0, 1'b0, lsig_pkg::REG_SURFACE, 0, 0, 0, 0, 0, 0, 1'b0},
        '{lsig_pkg::OP_NEXT,  4'd0,  1'b0, 1'b0, lsig_pkg::REG_SURFACE, 0, 0, 0, 0, 0, 0, 1'b0},
        '{lsig_pkg::OP_START, 4'd1,  1'b0, 1'b0, lsig_pkg::REG_SURFACE, 0, 0, 0, 0, 0, 0, 1'b0},
        '{lsig_pkg::OP_NEXT,  4'd0,  1'b0, 1'b0, lsig_pkg::REG_SURFACE, 0, 0, 0, 0, 0, 0, 1'b0},
        '{lsig_pkg::OP_NEXT,  4'd0,  1'b0, 1'b0, lsig_pkg::REG_SURFACE, 0, 0, 0, 0, 0, 0, 1'b0}
    };

    grid_lod_skirt_index_generator u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_start_req           (i_start_req),
        .i_lod_level           (i_lod_level),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_chunk_size_log2 (i_cfg_chunk_size_log2),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_valid_res           (o_valid_res),
        .o_region              (o_region),
        .o_first_index         (o_first_index),
        .o_second_index        (o_second_index),
        .o_third_index         (o_third_index),
        .o_fourth_index        (o_fourth_index),
        .o_fifth_index         (o_fifth_index),
        .o_sixth_index         (o_sixth_index),
        .o_last_quad           (o_last_quad)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // advance the quad walk by one transaction, returns 1 when a quad is due
    function automatic bit walk_quad(input lsig_pkg::t_op op, input logic [3:0] lod,
                                     output t_quad_res res);
        int unsigned l, n, stride, le, s, r, c, i, a, b, d, e, sv, v0, v1, v2, v3;
        int unsigned v [6];
        bit          last;
        logic [2:0]  rg;
        l      = (chunk_log2 > MAX_LOG2) ? MAX_LOG2 : chunk_log2;
        n      = 1 << l;
        stride = n + 1;
        le     = (run_lod > l) ? l : run_lod;
        s      = 1 << le;
        res    = '0;
        last   = 1'b0;
        v      = '{default: 0};
        if (op == lsig_pkg::OP_START) begin
            run_on     = 1'b1;
            run_lod    = lod;
            row_pos    = 0;
            col_pos    = 0;
            cur_region = lsig_pkg::REG_SURFACE;
            return 1'b0;
        end
        if (!run_on || cur_region > lsig_pkg::REG_BOTTOM) begin
            run_on = 1'b0;
            return 1'b1;
        end
        // positions left past the edge by a size change move on
        if (cur_region == lsig_pkg::REG_SURFACE) begin
            if (col_pos >= n) begin
                col_pos = 0;
                row_pos = row_pos + s;
            end
            if (row_pos >= n) begin
                cur_region = lsig_pkg::REG_LEFT;
                col_pos    = 0;
            end
        end
        while (cur_region >= lsig_pkg::REG_LEFT && cur_region <= lsig_pkg::REG_BOTTOM
               && col_pos >= n) begin
            cur_region = cur_region + 3'd1;
            col_pos    = 0;
        end
        if (cur_region > lsig_pkg::REG_BOTTOM) begin
            run_on = 1'b0;
            return 1'b1;
        end
        rg = cur_region;
        if (rg == lsig_pkg::REG_SURFACE) begin
            // surface quad, corners a b on row r and d e on row r+s
            r = row_pos;
            c = col_pos;
            a = r * stride + c;
            b = a + s;
            d = (r + s) * stride + c;
            e = d + s;
            v = '{d, b, a, e, b, d};
            col_pos = c + s;
            if (col_pos >= n) begin
                col_pos = 0;
                row_pos = r + s;
                if (row_pos >= n) begin
                    row_pos    = 0;
                    cur_region = lsig_pkg::REG_LEFT;
                end
            end
        end else begin
            // skirt quad, edge vertices v0 v1 and skirt vertices v2 v3
            i  = col_pos;
            sv = stride * stride + (rg - 3'd1) * stride + i;
            v2 = sv;
            v3 = sv + s;
            case (rg)
                lsig_pkg::REG_LEFT: begin
                    v0 = i * stride;
                    v1 = (i + s) * stride;
                end
                lsig_pkg::REG_RIGHT: begin
                    v0 = i * stride + n;
                    v1 = (i + s) * stride + n;
                end
                lsig_pkg::REG_TOP: begin
                    v0 = i;
                    v1 = i + s;
                end
                default: begin
                    v0 = i + stride * n;
                    v1 = i + s + stride * n;
                end
            endcase
            if (rg == lsig_pkg::REG_LEFT || rg == lsig_pkg::REG_BOTTOM)
                v = '{v0, v3, v1, v0, v2, v3};
            else
                v = '{v0, v1, v2, v1, v3, v2};
            col_pos = i + s;
            if (col_pos >= n) begin
                col_pos = 0;
                if (rg == lsig_pkg::REG_BOTTOM) begin
                    last       = 1'b1;
                    run_on     = 1'b0;
                    cur_region = lsig_pkg::REG_SURFACE;
                end else begin
                    cur_region = rg + 3'd1;
                end
            end
        end
        row_pos = row_pos & 'h1FF;
        col_pos = col_pos & 'h1FF;
        res.valid_res = 1'b1;
        res.region    = rg;
        for (int k = 0; k < 6; k++) res.idx[k] = lsig_pkg::IW'(v[k]);
        res.last = last;
        return 1'b1;
    endfunction

    function automatic string quad_text(input t_quad_res q);
        return $sformatf("vr=%0d rg=%0d idx=%0d,%0d,%0d,%0d,%0d,%0d last=%0d",
                         q.valid_res, q.region, q.idx[0], q.idx[1], q.idx[2],
                         q.idx[3], q.idx[4], q.idx[5], q.last);
    endfunction

    function automatic void push_req(input lsig_pkg::t_op op, input logic [3:0] lod,
                                     input bit pause);
        t_req rq;
        rq       = '0;
        rq.op    = op;
        rq.lod   = lod;
        rq.pause = pause;
        req_q.push_back(rq);
    endfunction

    // receiver stall pattern, one long hold-off counted in cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (hold_req != 0 && !hold_done) begin
                hold_left = hold_req;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // both channels: result check and request driving
    always @(posedge i_clk) begin
        t_quad_res got, want, pred;
        t_req      rq;
        bit        offer;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            // result transaction against the oldest expectation
            if (o_valid && !i_stall) begin
                got.valid_res = o_valid_res;
                got.region    = o_region;
                got.idx       = {o_first_index, o_second_index, o_third_index,
                                 o_fourth_index, o_fifth_index, o_sixth_index};
                got.last      = o_last_quad;
                if (quad_q.size() == 0) begin
                    if (err_cnt < 10) $display("unexpected quad at %0t: %s", $time, quad_text(got));
                    err_cnt++;
                end else begin
                    want = quad_q.pop_front();
                    if (got !== want) begin
                        if (err_cnt < 10)
                            $display("quad mismatch at %0t: expected %s, got %s",
                                     $time, quad_text(want), quad_text(got));
                        err_cnt++;
                    end
                end
            end

            // accepted request transaction feeds the predictor
            if (i_valid && !o_stall) begin
                rq = req_q.pop_front();
                if (walk_quad(rq.op, rq.lod, pred)) quad_q.push_back(rq.typed ? rq.res : pred);
            end

            // present the next request unless the current one is held
            if (!i_valid || !o_stall) begin
                offer = 1'b0;
                rq    = '0;
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    rq = req_q[0];
                    if (!rq.pause || quad_q.size() == 0) offer = 1'b1;
                end
                i_valid <= offer;
                if (offer) begin
                    i_start_req <= rq.op;
                    i_lod_level <= rq.lod;
                end
            end
        end
    end

    // wait until all requests went in and all quads came out
    task automatic settle_block();
        while (req_q.size() != 0 || quad_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_chunk_log2(input logic [3:0] val);
        @(posedge i_clk);
        i_cfg_valid           <= 1'b1;
        i_cfg_chunk_size_log2 <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        chunk_log2 = val;
    endtask

    // mostly complete runs, some overrun and some cut short by a restart
    task automatic queue_random_runs(input int count, input int unsigned l,
                                     input int unsigned lod_lo, input int pause_at);
        int         made, nexts, len, q, roll;
        logic [3:0] lod;
        made = 0;
        // carry on with the run left open by the previous setting
        repeat ($urandom_range(2, 1)) begin
            push_req(lsig_pkg::OP_NEXT, 4'($urandom), made == pause_at);
            made++;
        end
        while (made < count) begin
            lod = 4'($urandom_range(15, lod_lo));
            push_req(lsig_pkg::OP_START, lod, made == pause_at);
            made++;
            q   = 1 << (l - ((lod > l) ? l : lod));
            len = q * q + 4 * q;
            roll = $urandom_range(99);
            if (roll < 70) nexts = len;
            else if (roll < 85) nexts = len + $urandom_range(3, 1);
            else nexts = $urandom_range(len - 1, 0);
            repeat (nexts) begin
                push_req(lsig_pkg::OP_NEXT, 4'($urandom), made == pause_at);
                made++;
            end
        end
        // leave a run open across the coming size change
        push_req(lsig_pkg::OP_START, 4'($urandom), 1'b0);
        repeat ($urandom_range(3, 1)) push_req(lsig_pkg::OP_NEXT, 4'($urandom), 1'b0);
    endtask

    // stimulus sequence
    initial begin
        t_req rq;
        int   wait_cnt;
        i_rst_n               = 1'b0;
        i_cfg_valid           = 1'b0;
        i_cfg_chunk_size_log2 = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table at the reset chunk size
        @(negedge i_clk);
        foreach (dir_tab[r]) begin
            rq               = '0;
            rq.op            = dir_tab[r].op;
            rq.lod           = dir_tab[r].lod;
            rq.typed         = dir_tab[r].typed;
            rq.res.valid_res = dir_tab[r].vr;
            rq.res.region    = dir_tab[r].rg;
            rq.res.idx       = {lsig_pkg::IW'(dir_tab[r].i0), lsig_pkg::IW'(dir_tab[r].i1),
                                lsig_pkg::IW'(dir_tab[r].i2), lsig_pkg::IW'(dir_tab[r].i3),
                                lsig_pkg::IW'(dir_tab[r].i4), lsig_pkg::IW'(dir_tab[r].i5)};
            rq.res.last      = dir_tab[r].last;
            req_q.push_back(rq);
        end
        settle_block();

        // single tile chunk, no idling
        write_chunk_log2(4'd0);
        @(negedge i_clk);
        queue_random_runs(100, 0, 0, -1);
        settle_block();

        // sender mostly idle
        write_chunk_log2(4'd2);
        @(negedge i_clk);
        send_idle_pct = 82;
        stall_pct     = 0;
        queue_random_runs(150, 2, 0, -1);
        settle_block();

        // receiver mostly stalling
        write_chunk_log2(4'd3);
        @(negedge i_clk);
        send_idle_pct = 0;
        stall_pct     = 82;
        queue_random_runs(150, 3, 0, -1);
        settle_block();

        // largest chunk, coarse levels, both sides idling
        write_chunk_log2(4'd8);
        @(negedge i_clk);
        send_idle_pct = 38;
        stall_pct     = 38;
        queue_random_runs(150, 8, 5, -1);
        settle_block();

        // oversized register value saturates to the largest chunk
        write_chunk_log2(4'd15);
        @(negedge i_clk);
        send_idle_pct = 0;
        stall_pct     = 0;
        queue_random_runs(100, 8, 6, -1);
        settle_block();

        // long receiver hold-off while requests keep coming
        write_chunk_log2(4'd1);
        @(negedge i_clk);
        queue_random_runs(150, 1, 0, -1);
        hold_req = 60;
        settle_block();

        // sender waits for the pipe to drain midway
        write_chunk_log2(4'd3);
        @(negedge i_clk);
        send_idle_pct = 38;
        stall_pct     = 38;
        queue_random_runs(150, 3, 0, 75);

        // drain, then wait quietly for stray results
        for (wait_cnt = 0; wait_cnt < 20000 && (req_q.size() != 0 || quad_q.size() != 0);
             wait_cnt++)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (req_q.size() != 0) begin
            $display("%0d requests never accepted", req_q.size());
            err_cnt++;
        end
        if (quad_q.size() != 0) begin
            $display("%0d quads never arrived", quad_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("grid_lod_skirt_index_generator regression: pass");
        end else begin
            $display("grid_lod_skirt_index_generator regression: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("grid_lod_skirt_index_generator regression: fail");
        $finish;
    end

endmodule
